>>> rtl/core/assert_macros.svh
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check on every edge outside reset.
`define ASSERT_CLK(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Check on every edge, reset included.
`define ASSERT_ALWAYS(label, clk, prop, msg) \
   label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

>>> rtl/core/vilrm_pkg.sv
`timescale 1ns / 1ps
package vilrm_pkg;

   localparam int SLOT_W          = 6;
   localparam int WORD_W          = 32;
   localparam int CNT_W           = 7;
   localparam int MASK_W          = 64;
   localparam int ID_W            = 10;
   localparam int PRIO_W          = 8;
   localparam int DEF_MAX_ENTRIES = 64;
   localparam logic [CNT_W-1:0] ENTRIES_RESET = 7'd4;

   typedef enum logic [1:0] {
      CMD_INJECT = 2'd0,
      CMD_CLEAR  = 2'd1,
      CMD_READ   = 2'd2,
      CMD_WRITE  = 2'd3
   } cmd_type;

   // Pack an inject descriptor: vid 9:0, phys/source 19:10, prio 27:23, state 29:28, hw 31.
   function automatic logic [WORD_W-1:0] pack_desc(
      input logic [ID_W-1:0]   vid,
      input logic [1:0]        st,
      input logic [PRIO_W-1:0] prio,
      input logic              hw,
      input logic [ID_W-1:0]   src,
      input logic              maint
   );
      logic [ID_W-1:0] phys;
      phys = hw ? src : {maint, 6'd0, src[2:0]};
      return {hw, 1'b0, st, prio[7:3], 3'd0, phys, vid};
   endfunction

endpackage

>>> rtl/core/virtual_irq_list_register_manager.sv
`timescale 1ns / 1ps
// Virtual interrupt list-entry manager. Holds up to MAX_ENTRIES 32-bit list
// entries in a one-port-write, one-port-read synchronous RAM; csr_entries_in_use
// sets how many are live (values above MAX_ENTRIES act as MAX_ENTRIES, zero
// leaves no entries). Commands: inject packs a descriptor and stores it in the
// preferred slot if free, else the lowest free slot, else answers busy; clear
// drops every live entry flagged in done_mask; read and write give raw access
// for context save and restore. An entry is free when its state bits 29:28 are
// zero. Every request beat yields exactly one response beat. The edge that
// takes a request beat also registers the RAM read; the update stage then
// applies the update and loads the response register. A new request beat is
// taken only once the previous one has left the update stage, and a response
// stalled by rsp_ready holds the update stage until it leaves. The response
// register lets the next request enter while a response waits. A per-entry
// valid bit cleared at reset makes the RAM read as zero until written, so no
// clearing pass is needed after reset. Write the count register only while
// idle.
module virtual_irq_list_register_manager
   import vilrm_pkg::*;
#(
   parameter int MAX_ENTRIES = DEF_MAX_ENTRIES
) (
   input  logic                clock,
   input  logic                reset,
   // request channel
   input  logic                req_valid,
   output logic                req_ready,
   input  logic [1:0]          req_command,
   input  logic [ID_W-1:0]     req_virtual_id,
   input  logic [SLOT_W-1:0]   req_slot_choice,
   input  logic [1:0]          req_irq_state,
   input  logic [PRIO_W-1:0]   req_priority_level,
   input  logic                req_hardware_linked,
   input  logic [ID_W-1:0]     req_source_id,
   input  logic                req_want_maintenance,
   input  logic [MASK_W-1:0]   req_done_mask,
   input  logic [WORD_W-1:0]   req_raw_word,
   // response channel
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output logic                rsp_outcome,
   output logic [SLOT_W-1:0]   rsp_chosen_slot,
   output logic [WORD_W-1:0]   rsp_entry_word,
   // count register
   input  logic                csr_valid,
   output logic                csr_ready,
   input  logic [CNT_W-1:0]    csr_entries_in_use
);

   localparam int AW = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;

   typedef enum logic [1:0] {
      ST_IDLE = 2'b01,
      ST_EXEC = 2'b10
   } state_type;

   // Entry RAM and per-entry flags.
   logic [WORD_W-1:0]      mem [MAX_ENTRIES];
   logic [MAX_ENTRIES-1:0] valid_ff, valid_in;   // entry written since reset/clear
   logic [MAX_ENTRIES-1:0] occ_ff, occ_in;       // state bits nonzero

   state_type              state_ff, state_in;
   logic [CNT_W-1:0]       count_ff, count_in;

   // Item held for the update cycle.
   cmd_type                cmd_ff;
   logic [SLOT_W-1:0]      slot_ff;
   logic [WORD_W-1:0]      word_ff;
   logic [MASK_W-1:0]      mask_ff;
   logic [WORD_W-1:0]      rd_data_ff;

   // Response register.
   logic                   rsp_valid_ff, rsp_valid_in;
   logic                   rsp_outcome_ff, rsp_outcome_in;
   logic [SLOT_W-1:0]      rsp_slot_ff, rsp_slot_in;
   logic [WORD_W-1:0]      rsp_word_ff, rsp_word_in;

   logic                   req_fire;
   logic                   exec_fire;
   logic [CNT_W-1:0]       n_live;
   logic [MAX_ENTRIES-1:0] live;
   logic [MAX_ENTRIES-1:0] free_vec;
   logic                   idx_live;
   logic                   pref_free;
   logic                   any_free;
   logic [SLOT_W-1:0]      low_free;
   logic [SLOT_W-1:0]      target;
   logic                   mem_we;
   logic [AW-1:0]          mem_addr;
   logic [WORD_W-1:0]      mem_wdata;

   assign req_ready = (state_ff == ST_IDLE);
   assign req_fire  = req_valid && req_ready;
   assign csr_ready = 1'b1;

   // Drain the update stage when the response register is empty or emptying.
   assign exec_fire = (state_ff == ST_EXEC) && (!rsp_valid_ff || rsp_ready);

   // Clamp the live count to the implemented depth.
   assign n_live = (count_ff > CNT_W'(MAX_ENTRIES)) ? CNT_W'(MAX_ENTRIES) : count_ff;

   always_comb begin
      for (int i = 0; i < MAX_ENTRIES; i++) begin
         live[i]     = (CNT_W'(i) < n_live);
         free_vec[i] = live[i] && !occ_ff[i];
      end
   end

   assign idx_live  = ({1'b0, slot_ff} < n_live);
   assign pref_free = idx_live && free_vec[slot_ff[AW-1:0]];
   assign any_free  = |free_vec;

   // Lowest free slot: scan from the top so the lowest index wins.
   always_comb begin
      low_free = '0;
      for (int i = MAX_ENTRIES - 1; i >= 0; i--) begin
         if (free_vec[i]) begin
            low_free = SLOT_W'(i);
         end
      end
   end

   assign target = pref_free ? slot_ff : low_free;

   // Update stage: modify flags, write the RAM, load the response register.
   always_comb begin
      state_in       = state_ff;
      valid_in       = valid_ff;
      occ_in         = occ_ff;
      mem_we         = 1'b0;
      mem_addr       = slot_ff[AW-1:0];
      mem_wdata      = word_ff;
      rsp_valid_in   = rsp_valid_ff && !rsp_ready;
      rsp_outcome_in = rsp_outcome_ff;
      rsp_slot_in    = rsp_slot_ff;
      rsp_word_in    = rsp_word_ff;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               state_in = ST_EXEC;
            end
         end
         ST_EXEC: begin
            if (exec_fire) begin
               state_in       = ST_IDLE;
               rsp_valid_in   = 1'b1;
               rsp_outcome_in = 1'b0;
               rsp_slot_in    = '0;
               rsp_word_in    = '0;
               unique case (cmd_ff)
                  CMD_INJECT: begin
                     rsp_word_in = word_ff;
                     if (pref_free || any_free) begin
                        mem_we                   = 1'b1;
                        mem_addr                 = target[AW-1:0];
                        valid_in[target[AW-1:0]] = 1'b1;
                        occ_in[target[AW-1:0]]   = (word_ff[29:28] != 2'd0);
                        rsp_slot_in              = target;
                     end else begin
                        rsp_outcome_in = 1'b1;
                     end
                  end
                  CMD_CLEAR: begin
                     // Drop flagged live entries; invalid entries read as zero.
                     for (int i = 0; i < MAX_ENTRIES; i++) begin
                        if (live[i] && mask_ff[i]) begin
                           valid_in[i] = 1'b0;
                           occ_in[i]   = 1'b0;
                        end
                     end
                  end
                  CMD_READ: begin
                     rsp_slot_in = slot_ff;
                     if (idx_live && valid_ff[slot_ff[AW-1:0]]) begin
                        rsp_word_in = rd_data_ff;
                     end
                  end
                  CMD_WRITE: begin
                     rsp_slot_in = slot_ff;
                     if (idx_live) begin
                        mem_we                    = 1'b1;
                        valid_in[slot_ff[AW-1:0]] = 1'b1;
                        occ_in[slot_ff[AW-1:0]]   = (word_ff[29:28] != 2'd0);
                        rsp_word_in               = word_ff;
                     end
                  end
                  default: begin
                     rsp_word_in = '0;
                  end
               endcase
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign count_in = csr_valid ? csr_entries_in_use : count_ff;

   // Control state.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         valid_ff     <= '0;
         occ_ff       <= '0;
         count_ff     <= ENTRIES_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         valid_ff     <= valid_in;
         occ_ff       <= occ_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Capture the request beat; pack the descriptor on the way in.
   always_ff @(posedge clock) begin
      if (req_fire) begin
         cmd_ff  <= cmd_type'(req_command);
         slot_ff <= req_slot_choice;
         mask_ff <= req_done_mask;
         word_ff <= (cmd_type'(req_command) == CMD_WRITE) ? req_raw_word :
                    pack_desc(req_virtual_id, req_irq_state, req_priority_level,
                              req_hardware_linked, req_source_id, req_want_maintenance);
      end
   end

   // Entry RAM: read issued with the request beat, write from the update stage.
   always_ff @(posedge clock) begin
      if (req_fire) begin
         rd_data_ff <= mem[req_slot_choice[AW-1:0]];
      end
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_addr] <= mem_wdata;
      end
   end

   // Response register payload.
   always_ff @(posedge clock) begin
      rsp_outcome_ff <= rsp_outcome_in;
      rsp_slot_ff    <= rsp_slot_in;
      rsp_word_ff    <= rsp_word_in;
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_outcome     = rsp_outcome_ff;
   assign rsp_chosen_slot = rsp_slot_ff;
   assign rsp_entry_word  = rsp_word_ff;

endmodule

>>> rtl/core/vilrm_checker.sv
`timescale 1ns / 1ps
`include "assert_macros.svh"
module vilrm_checker
   import vilrm_pkg::*;
(
   input logic                clock,
   input logic                reset,
   input logic                req_valid,
   input logic                req_ready,
   input logic                rsp_valid,
   input logic                rsp_ready,
   input logic                rsp_outcome,
   input logic [SLOT_W-1:0]   rsp_chosen_slot,
   input logic [WORD_W-1:0]   rsp_entry_word
);

   // Beats taken in but not yet answered.
   logic [1:0] pend_ff, pend_in;
   logic       req_beat;
   logic       rsp_beat;
   logic       stall;
   logic [WORD_W+SLOT_W:0] payload;

   assign req_beat = req_valid && req_ready;
   assign rsp_beat = rsp_valid && rsp_ready;
   assign stall    = rsp_valid && !rsp_ready;
   assign payload  = {rsp_outcome, rsp_chosen_slot, rsp_entry_word};

   always_comb begin
      pend_in = pend_ff;
      if (req_beat && !rsp_beat) begin
         pend_in = pend_ff + 2'd1;
      end else if (!req_beat && rsp_beat) begin
         pend_in = pend_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pend_ff <= '0;
      end else begin
         pend_ff <= pend_in;
      end
   end

   `ASSERT_CLK(a_rsp_hold, clock, reset, stall |=> rsp_valid && $stable(payload), "beat not held")
   `ASSERT_CLK(a_pend_bound, clock, reset, pend_ff != 2'd3, "more than two requests outstanding")
   `ASSERT_CLK(a_rsp_has_req, clock, reset, rsp_valid |-> pend_ff != 2'd0, "orphan response")
   `ASSERT_ALWAYS(a_reset_quiet, clock, reset |=> !rsp_valid, "response valid right after reset")

endmodule

bind virtual_irq_list_register_manager vilrm_checker u_vilrm_checker (.*);
